// File: design/assert_macros.svh
// assertion macros used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define VRN_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled while in reset
`define VRN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: design/vrn_pkg.sv
// shared constants and control type for the vector reflection pipeline
package vrn_pkg;

  localparam int NORM_W   = 32;
  localparam int SUM_W    = 64;
  localparam int ROOT_W   = 32;
  localparam int REM_W    = ROOT_W + 2;
  localparam int PREP_LAT = 5;
  localparam int SQRT_LAT = 16;

  typedef struct packed {
    logic vld;
    logic zero;
  } vrn_ctl_t;

endpackage

// File: design/vrn_prep.sv
// normal magnitudes, normalising shift and sum of squares
module vrn_prep #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  vrn_pkg::vrn_ctl_t                 ctl_i,
  input  logic signed [DATA_WIDTH-1:0]      n_i [3],
  output vrn_pkg::vrn_ctl_t                 ctl_o,
  output logic [vrn_pkg::NORM_W-1:0]        a_o [3],
  output logic [vrn_pkg::SUM_W-1:0]         s_o
);
  import vrn_pkg::*;

  vrn_ctl_t            ctl_r [PREP_LAT];
  vrn_ctl_t            ctl_nxt [PREP_LAT];
  logic [NORM_W-1:0]   a1_r [3];
  logic [NORM_W-1:0]   a1_nxt [3];
  logic [NORM_W-1:0]   a2_r [3];
  logic [NORM_W-1:0]   w2_r;
  logic [NORM_W-1:0]   w2_nxt;
  logic [4:0]          k2_r;
  logic [4:0]          k2_nxt;
  logic [NORM_W-1:0]   a3_r [3];
  logic [NORM_W-1:0]   a3_nxt [3];
  logic [NORM_W-1:0]   a4_r [3];
  logic [SUM_W-1:0]    sq4_r [3];
  logic [SUM_W-1:0]    sq4_nxt [3];
  logic [NORM_W-1:0]   a5_r [3];
  logic [SUM_W-1:0]    s5_r;
  logic [SUM_W-1:0]    s5_nxt;
  logic [DATA_WIDTH-1:0] mag [3];
  logic [NORM_W-1:0]   w;
  logic [NORM_W-1:0]   w3;
  logic [4:0]          k3;
  logic [4:0]          kk;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i]    = n_i[i][DATA_WIDTH-1] ? DATA_WIDTH'(-n_i[i]) : DATA_WIDTH'(n_i[i]);
      a1_nxt[i] = NORM_W'(mag[i]);
    end
  end

  // leading-zero search in two stages: coarse steps, then fine steps
  always_comb begin
    w      = a1_r[0] | a1_r[1] | a1_r[2];
    w2_nxt = w;
    k2_nxt = '0;
    if (w2_nxt[NORM_W-1 -: 16] == '0) begin
      w2_nxt    = w2_nxt << 16;
      k2_nxt[4] = 1'b1;
    end
    if (w2_nxt[NORM_W-1 -: 8] == '0) begin
      w2_nxt    = w2_nxt << 8;
      k2_nxt[3] = 1'b1;
    end
    if (w2_nxt[NORM_W-1 -: 4] == '0) begin
      w2_nxt    = w2_nxt << 4;
      k2_nxt[2] = 1'b1;
    end
  end

  always_comb begin
    w3 = w2_r;
    k3 = k2_r;
    if (w3[NORM_W-1 -: 2] == '0) begin
      w3    = w3 << 2;
      k3[1] = 1'b1;
    end
    if (!w3[NORM_W-1]) begin
      k3[0] = 1'b1;
    end
    // aim for the top bit one below the msb
    kk = (k3 == '0) ? 5'd0 : k3 - 5'd1;
    for (int i = 0; i < 3; i++) begin
      a3_nxt[i] = a2_r[i] << kk;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq4_nxt[i] = SUM_W'(a3_r[i]) * SUM_W'(a3_r[i]);
    end
    s5_nxt = sq4_r[0] + sq4_r[1] + sq4_r[2];
  end

  always_comb begin
    ctl_nxt[0] = ctl_i;
    for (int k = 1; k < PREP_LAT; k++) begin
      ctl_nxt[k] = ctl_r[k-1];
    end
    ctl_nxt[1].zero = (w == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < PREP_LAT; k++) begin
        ctl_r[k] <= '0;
      end
    end else begin
      for (int k = 0; k < PREP_LAT; k++) begin
        ctl_r[k] <= ctl_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    a1_r  <= a1_nxt;
    a2_r  <= a1_r;
    w2_r  <= w2_nxt;
    k2_r  <= k2_nxt;
    a3_r  <= a3_nxt;
    a4_r  <= a3_r;
    sq4_r <= sq4_nxt;
    a5_r  <= a4_r;
    s5_r  <= s5_nxt;
  end

  assign ctl_o = ctl_r[PREP_LAT-1];
  assign a_o   = a5_r;
  assign s_o   = s5_r;

endmodule

// File: design/vrn_isqrt.sv
// pipelined integer square root, two result bits per stage
module vrn_isqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  vrn_pkg::vrn_ctl_t           ctl_i,
  input  logic [vrn_pkg::SUM_W-1:0]   s_i,
  output vrn_pkg::vrn_ctl_t           ctl_o,
  output logic [vrn_pkg::ROOT_W-1:0]  q_o
);
  import vrn_pkg::*;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sq_t;

  function automatic sq_t sq_step(input sq_t st, input logic [1:0] pr);
    sq_t              o;
    logic [REM_W-1:0] r2;
    logic [REM_W-1:0] tr;
    r2 = {st.rem[REM_W-3:0], pr};
    tr = {st.root, 2'b01};
    if (r2 >= tr) begin
      o.rem  = r2 - tr;
      o.root = {st.root[ROOT_W-2:0], 1'b1};
    end else begin
      o.rem  = r2;
      o.root = {st.root[ROOT_W-2:0], 1'b0};
    end
    return o;
  endfunction

  sq_t              st_r   [SQRT_LAT];
  sq_t              st_nxt [SQRT_LAT];
  logic [SUM_W-1:0] s_r    [SQRT_LAT];
  logic [SUM_W-1:0] s_nxt  [SQRT_LAT];
  vrn_ctl_t         ctl_r  [SQRT_LAT];
  vrn_ctl_t         ctl_nxt [SQRT_LAT];

  for (genvar k = 0; k < SQRT_LAT; k++) begin : g_st
    sq_t              st_src;
    logic [SUM_W-1:0] s_src;
    vrn_ctl_t         c_src;
    if (k == 0) begin : g_in
      assign st_src = '0;
      assign s_src  = s_i;
      assign c_src  = ctl_i;
    end else begin : g_mid
      assign st_src = st_r[k-1];
      assign s_src  = s_r[k-1];
      assign c_src  = ctl_r[k-1];
    end
    assign st_nxt[k]  = sq_step(sq_step(st_src, s_src[SUM_W-1 -: 2]), s_src[SUM_W-3 -: 2]);
    assign s_nxt[k]   = s_src << 4;
    assign ctl_nxt[k] = c_src;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < SQRT_LAT; k++) begin
        ctl_r[k] <= '0;
      end
    end else begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    st_r <= st_nxt;
    s_r  <= s_nxt;
  end

  assign ctl_o = ctl_r[SQRT_LAT-1];
  assign q_o   = st_r[SQRT_LAT-1].root;

endmodule

// File: design/vrn_div.sv
// three-lane pipelined restoring divider, one quotient bit per stage after the input stage
module vrn_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  vrn_pkg::vrn_ctl_t           ctl_i,
  input  logic [vrn_pkg::NORM_W-1:0]  a_i [3],
  input  logic [vrn_pkg::ROOT_W-1:0]  q_i,
  output vrn_pkg::vrn_ctl_t           ctl_o,
  output logic [FRAC_BITS:0]          um_o [3]
);
  import vrn_pkg::*;

  localparam int NW  = FRAC_BITS + NORM_W + 2;
  localparam int QW  = FRAC_BITS + 1;
  localparam int NST = FRAC_BITS + 2;

  vrn_ctl_t          ctl_r   [NST];
  vrn_ctl_t          ctl_nxt [NST];
  logic [ROOT_W-1:0] q_r     [NST];
  logic [ROOT_W-1:0] q_nxt   [NST];
  logic [NW-1:0]     rem_r   [NST][3];
  logic [NW-1:0]     rem_nxt [NST][3];
  logic [QW-1:0]     quo_r   [NST][3];
  logic [QW-1:0]     quo_nxt [NST][3];

  for (genvar k = 0; k < NST; k++) begin : g_st
    if (k == 0) begin : g_in
      // numerator with half the divisor added for rounding
      for (genvar i = 0; i < 3; i++) begin : g_ln
        assign rem_nxt[0][i] = (NW'(a_i[i]) << FRAC_BITS) + NW'(q_i >> 1);
        assign quo_nxt[0][i] = '0;
      end
      assign q_nxt[0]   = q_i;
      assign ctl_nxt[0] = ctl_i;
    end else begin : g_mid
      localparam int B = NST - 1 - k;
      logic [NW-1:0] dv;
      assign dv = NW'(q_r[k-1]) << B;
      for (genvar i = 0; i < 3; i++) begin : g_ln
        logic ge;
        assign ge            = rem_r[k-1][i] >= dv;
        assign rem_nxt[k][i] = ge ? rem_r[k-1][i] - dv : rem_r[k-1][i];
        assign quo_nxt[k][i] = {quo_r[k-1][i][QW-2:0], ge};
      end
      assign q_nxt[k]   = q_r[k-1];
      assign ctl_nxt[k] = ctl_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NST; k++) begin
        ctl_r[k] <= '0;
      end
    end else begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign ctl_o = ctl_r[NST-1];
  assign um_o  = quo_r[NST-1];

endmodule

// File: design/vrn_reflect.sv
// dot product, scaled subtraction, saturation, zero-normal bypass
module vrn_reflect #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  vrn_pkg::vrn_ctl_t             ctl_i,
  input  logic [FRAC_BITS:0]            um_i [3],
  input  logic                          neg_i [3],
  input  logic signed [DATA_WIDTH-1:0]  v_i [3],
  output logic                          valid_o,
  output logic signed [DATA_WIDTH-1:0]  r_o [3],
  output logic                          zero_o
);
  import vrn_pkg::*;

  localparam int NS = 6;
  localparam int UW = FRAC_BITS + 2;
  localparam int MW = DATA_WIDTH + UW;
  localparam int PW = DATA_WIDTH + FRAC_BITS + 4;
  localparam int DD = DATA_WIDTH + 3;
  localparam int QW = DD + UW + 1;
  localparam int TW = DATA_WIDTH + 7;

  vrn_ctl_t                ctl_r [NS];
  logic signed [DATA_WIDTH-1:0] v_r [NS-1][3];
  logic signed [UW-1:0]    u_r   [3];
  logic signed [UW-1:0]    u2_r  [3];
  logic signed [UW-1:0]    u3_r  [3];
  logic signed [UW-1:0]    u4_r  [3];
  logic signed [UW-1:0]    u_nxt [3];
  logic signed [MW-1:0]    pm    [3];
  logic signed [PW-1:0]    p_r   [3];
  logic signed [PW-1:0]    p_nxt [3];
  logic signed [PW-1:0]    sum_r;
  logic signed [PW-1:0]    sum_nxt;
  logic [PW-1:0]           m4;
  logic [PW-1:0]           r4;
  logic signed [DD-1:0]    d_r;
  logic signed [DD-1:0]    d_nxt;
  logic signed [DD+UW-1:0] pm2   [3];
  logic signed [QW-1:0]    q5_r  [3];
  logic signed [QW-1:0]    q5_nxt [3];
  logic [QW-1:0]           m6    [3];
  logic [QW-1:0]           r6    [3];
  logic signed [TW-1:0]    t6    [3];
  logic signed [TW-1:0]    diff  [3];
  logic signed [DATA_WIDTH-1:0] out_r   [3];
  logic signed [DATA_WIDTH-1:0] out_nxt [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      u_nxt[i] = neg_i[i] ? -$signed({1'b0, um_i[i]}) : $signed({1'b0, um_i[i]});
      pm[i]    = v_r[0][i] * u_r[i];
      p_nxt[i] = PW'(pm[i]);
    end
    sum_nxt = p_r[0] + p_r[1] + p_r[2];
  end

  // dot product back to component format, rounded half away from zero
  always_comb begin
    m4    = sum_r[PW-1] ? PW'(-sum_r) : PW'(sum_r);
    r4    = (m4 + (PW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    d_nxt = sum_r[PW-1] ? -$signed(DD'(r4)) : $signed(DD'(r4));
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pm2[i]    = d_r * u4_r[i];
      q5_nxt[i] = $signed({pm2[i], 1'b0});
      m6[i]     = q5_r[i][QW-1] ? QW'(-q5_r[i]) : QW'(q5_r[i]);
      r6[i]     = (m6[i] + (QW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
      t6[i]     = q5_r[i][QW-1] ? -$signed(TW'(r6[i])) : $signed(TW'(r6[i]));
      diff[i]   = TW'(v_r[NS-2][i]) - t6[i];
      if (ctl_r[NS-2].zero) begin
        out_nxt[i] = v_r[NS-2][i];
      end else if (diff[i][TW-1:DATA_WIDTH-1] == '0 || diff[i][TW-1:DATA_WIDTH-1] == '1) begin
        out_nxt[i] = diff[i][DATA_WIDTH-1:0];
      end else if (diff[i][TW-1]) begin
        out_nxt[i] = {1'b1, {(DATA_WIDTH-1){1'b0}}};
      end else begin
        out_nxt[i] = {1'b0, {(DATA_WIDTH-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NS; k++) begin
        ctl_r[k] <= '0;
      end
    end else begin
      ctl_r[0] <= ctl_i;
      for (int k = 1; k < NS; k++) begin
        ctl_r[k] <= ctl_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    v_r[0] <= v_i;
    for (int k = 1; k < NS-1; k++) begin
      v_r[k] <= v_r[k-1];
    end
    u_r   <= u_nxt;
    u2_r  <= u_r;
    u3_r  <= u2_r;
    u4_r  <= u3_r;
    p_r   <= p_nxt;
    sum_r <= sum_nxt;
    d_r   <= d_nxt;
    q5_r  <= q5_nxt;
    out_r <= out_nxt;
  end

  assign valid_o = ctl_r[NS-1].vld;
  assign zero_o  = ctl_r[NS-1].zero;
  assign r_o     = out_r;

endmodule

// File: design/vector_reflect_about_normal_top.sv
// top level of the vector reflection pipeline
//
//  channel   ports                                  handshake
//  input     in_incident_*, in_normal_*             start high and busy low
//  result    out_reflected_*, out_zero_normal       out_valid, one cycle
//
// one item enters per cycle; busy stays low
// result beat is taken after the prep, square root, divider and reflect stages
// stages: 5 prep, 16 square root, FRAC_BITS + 2 divider and 6 reflect
// reset clears the valid and zero-flag bits only; items in flight are dropped
// the receiver cannot stall, so the pipeline never holds
module vector_reflect_about_normal_top #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [DATA_WIDTH-1:0] in_incident_x,
  input  logic signed [DATA_WIDTH-1:0] in_incident_y,
  input  logic signed [DATA_WIDTH-1:0] in_incident_z,
  input  logic signed [DATA_WIDTH-1:0] in_normal_x,
  input  logic signed [DATA_WIDTH-1:0] in_normal_y,
  input  logic signed [DATA_WIDTH-1:0] in_normal_z,
  output logic                         out_valid,
  output logic signed [DATA_WIDTH-1:0] out_reflected_x,
  output logic signed [DATA_WIDTH-1:0] out_reflected_y,
  output logic signed [DATA_WIDTH-1:0] out_reflected_z,
  output logic                         out_zero_normal
);
  import vrn_pkg::*;
  `include "assert_macros.svh"

  localparam int DIV_LAT = FRAC_BITS + 2;
  localparam int VDLY    = PREP_LAT + SQRT_LAT + DIV_LAT;
  localparam int TOT_LAT = VDLY + 6;

  vrn_ctl_t          ctl_in;
  vrn_ctl_t          ctl_p;
  vrn_ctl_t          ctl_s;
  vrn_ctl_t          ctl_d;
  logic signed [DATA_WIDTH-1:0] n_in [3];
  logic signed [DATA_WIDTH-1:0] v_in [3];
  logic [NORM_W-1:0] a_p [3];
  logic [SUM_W-1:0]  s_p;
  logic [ROOT_W-1:0] q_s;
  logic [FRAC_BITS:0] um_d [3];
  logic [NORM_W-1:0] ad_r [SQRT_LAT][3];
  logic signed [DATA_WIDTH-1:0] vd_r [VDLY][3];
  logic              nd_r [VDLY][3];
  logic signed [DATA_WIDTH-1:0] r_out [3];
  logic              nrm_zero;

  assign busy   = 1'b0;
  assign ctl_in = '{vld: start & ~busy, zero: 1'b0};
  assign n_in   = '{in_normal_x, in_normal_y, in_normal_z};
  assign v_in   = '{in_incident_x, in_incident_y, in_incident_z};
  assign nrm_zero = (in_normal_x == '0) && (in_normal_y == '0) && (in_normal_z == '0);

  vrn_prep #(.DATA_WIDTH(DATA_WIDTH)) u_prep (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl_i (ctl_in),
    .n_i   (n_in),
    .ctl_o (ctl_p),
    .a_o   (a_p),
    .s_o   (s_p)
  );

  vrn_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl_i (ctl_p),
    .s_i   (s_p),
    .ctl_o (ctl_s),
    .q_o   (q_s)
  );

  // magnitudes wait alongside the square root
  always_ff @(posedge clk) begin
    ad_r[0] <= a_p;
    for (int k = 1; k < SQRT_LAT; k++) begin
      ad_r[k] <= ad_r[k-1];
    end
  end

  vrn_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl_i (ctl_s),
    .a_i   (ad_r[SQRT_LAT-1]),
    .q_i   (q_s),
    .ctl_o (ctl_d),
    .um_o  (um_d)
  );

  // incident vector and normal signs follow the beat to the reflect stage
  always_ff @(posedge clk) begin
    vd_r[0] <= v_in;
    for (int i = 0; i < 3; i++) begin
      nd_r[0][i] <= n_in[i][DATA_WIDTH-1];
    end
    for (int k = 1; k < VDLY; k++) begin
      vd_r[k] <= vd_r[k-1];
      nd_r[k] <= nd_r[k-1];
    end
  end

  vrn_reflect #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_reflect (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl_i   (ctl_d),
    .um_i    (um_d),
    .neg_i   (nd_r[VDLY-1]),
    .v_i     (vd_r[VDLY-1]),
    .valid_o (out_valid),
    .r_o     (r_out),
    .zero_o  (out_zero_normal)
  );

  assign out_reflected_x = r_out[0];
  assign out_reflected_y = r_out[1];
  assign out_reflected_z = r_out[2];

  `VRN_ASSERT_IMPL(a_lat, clk, rst_n, out_valid, $past(start, TOT_LAT))
  `VRN_ASSERT_IMPL(a_zero_src, clk, rst_n, out_valid && out_zero_normal, $past(nrm_zero, TOT_LAT))
  `VRN_ASSERT_IMPL(a_zero_pass, clk, rst_n, out_valid && out_zero_normal,
                   out_reflected_x == $past(in_incident_x, TOT_LAT)
                   && out_reflected_z == $past(in_incident_z, TOT_LAT))

endmodule
